// ----- rtl/gswe_pkg.sv -----
package gswe_pkg;

  // Field widths
  localparam int POS_W     = 18;
  localparam int W_W       = 18;
  localparam int GRAD_W    = 32;
  localparam int NODE_W    = 4;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_W    = 16;

  // Internal widths
  localparam int DIST_W   = 20;               // signed pos - offset
  localparam int K_W      = 19;               // |distance|, Q16
  localparam int S_W      = 34;               // axis value, Q34
  localparam int D_W      = 17;               // slope magnitude, Q17
  localparam int AX_W     = D_W + S_W;        // slope * other axis value
  localparam int SPLIT    = 25;               // low part of the split gradient multiply
  localparam int AX_HI_W  = AX_W - SPLIT;
  localparam int PHI_W    = AX_HI_W + CFG_W;
  localparam int PLO_W    = SPLIT + CFG_W;
  localparam int TOT_W    = AX_W + CFG_W + 1;
  localparam int MAG_W    = 31;
  localparam int WPROD_W  = 2 * S_W;
  localparam int W_SHIFT  = 52;
  localparam int G_SHIFT  = 51;
  localparam int WMAG_W   = WPROD_W - W_SHIFT;

  // Queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TWICE_INV_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWICE_INV_Y = 1'b1;
  localparam logic [CFG_W-1:0]     TWICE_INV_RESET = 32'h0001_0000;

  // Region edges in Q16
  localparam logic [K_W-1:0] HALF_CELL = 19'd32768;
  localparam logic [K_W-1:0] MID_EDGE  = 19'd98304;
  localparam logic [K_W-1:0] OUT_EDGE  = 19'd163840;
  localparam logic [K_W-1:0] TWO_CELL  = 19'd131072;

  localparam logic [S_W-1:0] S_SEVEN_EIGHTHS = S_W'(7) << 31;
  localparam logic [D_W-1:0] D_HALF_SLOPE    = D_W'(65536);

  localparam logic [WPROD_W-1:0] W_ROUND = WPROD_W'(1) << (W_SHIFT - 1);
  localparam logic [TOT_W-1:0]   G_ROUND = TOT_W'(1) << (G_SHIFT - 1);

  // Node offsets in cell half-widths
  localparam logic signed [2:0] NODE_OFF_X [16] = '{
    -3'sd1, 3'sd1, 3'sd1, -3'sd1, -3'sd3, -3'sd1, 3'sd1, 3'sd3,
    3'sd3, 3'sd3, 3'sd3, 3'sd1, -3'sd1, -3'sd3, -3'sd3, -3'sd3};
  localparam logic signed [2:0] NODE_OFF_Y [16] = '{
    -3'sd1, -3'sd1, 3'sd1, 3'sd1, -3'sd3, -3'sd3, -3'sd3, -3'sd3,
    -3'sd1, 3'sd1, 3'sd3, 3'sd3, 3'sd3, 3'sd3, 3'sd1, -3'sd1};

  typedef enum logic [1:0] {
    RG_INNER = 2'd0,
    RG_MID   = 2'd1,
    RG_OUTER = 2'd2,
    RG_ZERO  = 2'd3
  } region_t;

  typedef struct packed {
    logic [K_W-1:0] k;
    region_t        region;
    logic           neg;      // pos > offset, slope is negative
  } axis_t;

  typedef struct packed {
    axis_t ax;
    axis_t ay;
    logic  want;
    logic  last;
  } q_entry_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    logic [D_W-1:0] d;
  } shape_t;

endpackage

// ----- rtl/gswe_in_if.sv -----
interface gswe_in_if import gswe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [NODE_W-1:0]        node_id;
  logic                     want_grad;
  logic                     last_node;

  modport source (output valid, pos_x, pos_y, node_id, want_grad, last_node, input ready);
  modport sink   (input valid, pos_x, pos_y, node_id, want_grad, last_node, output ready);
endinterface

// ----- rtl/gswe_out_if.sv -----
interface gswe_out_if import gswe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [W_W-1:0]    weight;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     last_out;

  modport source (output valid, weight, grad_x, grad_y, last_out, input ready);
  modport sink   (input valid, weight, grad_x, grad_y, last_out, output ready);
endinterface

// ----- rtl/gswe_cfg_if.sv -----
interface gswe_cfg_if import gswe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gimp_shape_weight_eval_core.sv -----
// GIMP shape weight and gradient evaluator, one particle / grid node pair per item.
// in_ch  : valid/ready item with pos_x, pos_y (Q2.16), node_id, want_grad, last_node.
// out_ch : valid/ready item with weight (Q2.16), grad_x, grad_y (Q16.16), last_out.
// cfg_ch : valid/ready register write, index 0 = 2/cell width x, 1 = 2/cell height y,
//          unsigned Q16.16. Always ready; write only while no item is in flight.
// Throughput: one item per cycle while out_ch does not stall. The front end
// classifies the item and writes it into a four-entry queue; the back end is a
// five-stage pipeline (axis evaluation, 34x34 weight product, split 51x32
// cell-scale multiply, rounding, sign).
// When out_ch stalls, the back pipeline holds; the queue keeps accepting until it
// has four items waiting, then in_ch.ready drops.
// Reset (rst_n low, synchronous): queue and pipeline emptied, both scale registers
// return to 1.0.
module gimp_shape_weight_eval_core import gswe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gswe_in_if.sink     in_ch,
  gswe_out_if.source  out_ch,
  gswe_cfg_if.sink    cfg_ch
);

  logic [CFG_W-1:0] twice_inv_x_r, twice_inv_y_r;
  logic             q_full, q_push, q_valid, q_pop;
  q_entry_t         q_wr_data, q_rd_data;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twice_inv_x_r <= TWICE_INV_RESET;
      twice_inv_y_r <= TWICE_INV_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TWICE_INV_X: twice_inv_x_r <= cfg_ch.data;
        CFG_TWICE_INV_Y: twice_inv_y_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  gswe_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  gswe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .valid   (q_valid),
    .rd_data (q_rd_data),
    .pop     (q_pop)
  );

  gswe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .twice_inv_x (twice_inv_x_r),
    .twice_inv_y (twice_inv_y_r),
    .out_ch      (out_ch)
  );

endmodule

// ----- rtl/gswe_front.sv -----
module gswe_front import gswe_pkg::*; (
  gswe_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_data
);

  // Distance to the node, its magnitude, sign and region
  function automatic axis_t classify(logic signed [POS_W-1:0] pos, logic signed [2:0] off);
    logic signed [DIST_W-1:0] d;
    logic [DIST_W-1:0]        mag;
    axis_t                    a;
    d     = DIST_W'(pos) - $signed({off[2], off, {FRAC_W{1'b0}}});
    mag   = d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
    a.k   = mag[K_W-1:0];
    a.neg = !d[DIST_W-1] && (d != '0);
    if (a.k <= HALF_CELL) begin
      a.region = RG_INNER;
    end else if (a.k <= MID_EDGE) begin
      a.region = RG_MID;
    end else if (a.k <= OUT_EDGE) begin
      a.region = RG_OUTER;
    end else begin
      a.region = RG_ZERO;
    end
    return a;
  endfunction

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_data.ax   = classify(in_ch.pos_x, NODE_OFF_X[in_ch.node_id]);
    q_data.ay   = classify(in_ch.pos_y, NODE_OFF_Y[in_ch.node_id]);
    q_data.want = in_ch.want_grad;
    q_data.last = in_ch.last_node;
  end

endmodule

// ----- rtl/gswe_queue.sv -----
module gswe_queue import gswe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_data,
  output logic     full,
  output logic     valid,
  output q_entry_t rd_data,
  input  logic     pop
);

  q_entry_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = entry_r[rd_ptr_r];
  assign do_pop  = pop && valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/gswe_back.sv -----
module gswe_back import gswe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  q_entry_t         q_data,
  output logic             q_pop,
  input  logic [CFG_W-1:0] twice_inv_x,
  input  logic [CFG_W-1:0] twice_inv_y,
  gswe_out_if.source       out_ch
);

  // Piecewise-quadratic axis value and slope magnitude
  function automatic shape_t axis_eval(axis_t a);
    logic [K_W-1:0] n;
    logic [K_W-1:0] m;
    logic [15:0]    sq_in;
    logic [31:0]    sq;
    shape_t         r;
    n     = OUT_EDGE - a.k;
    m     = TWO_CELL - a.k;
    sq_in = (a.region == RG_INNER) ? a.k[15:0] : n[15:0];
    sq    = 32'(sq_in) * 32'(sq_in);
    case (a.region)
      RG_INNER: begin
        r.s = S_SEVEN_EIGHTHS - S_W'({sq, 1'b0});
        r.d = D_W'({a.k[15:0], 1'b0});
      end
      RG_MID: begin
        r.s = {m[16:0], 17'b0};
        r.d = D_HALF_SLOPE;
      end
      RG_OUTER: begin
        r.s = S_W'(sq);
        r.d = D_W'(n[15:0]);
      end
      default: begin
        r.s = '0;
        r.d = '0;
      end
    endcase
    return r;
  endfunction

  logic adv;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;

  shape_t              s1_x_r, s1_y_r;
  logic                s1_negx_r, s1_negy_r, s1_want_r, s1_last_r;

  logic [WPROD_W-1:0]  s2_wprod_r;
  logic [AX_W-1:0]     s2_ax_r, s2_ay_r;
  logic                s2_negx_r, s2_negy_r, s2_want_r, s2_last_r;

  logic [WMAG_W-1:0]   s3_weight_r;
  logic [PHI_W-1:0]    s3_phx_r, s3_phy_r;
  logic [PLO_W-1:0]    s3_plx_r, s3_ply_r;
  logic                s3_negx_r, s3_negy_r, s3_want_r, s3_last_r;

  logic [WMAG_W-1:0]   s4_weight_r;
  logic [MAG_W-1:0]    s4_magx_r, s4_magy_r;
  logic                s4_negx_r, s4_negy_r, s4_last_r;

  logic signed [W_W-1:0]    out_weight_r;
  logic signed [GRAD_W-1:0] out_gx_r, out_gy_r;
  logic                     out_last_r;

  logic [WPROD_W-1:0] wsum;
  logic [TOT_W-1:0]   totx, toty;

  // Whole pipe moves unless the output item is held
  assign adv   = !out_v_r || out_ch.ready;
  assign q_pop = q_valid && adv;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // Rounding sums
  assign wsum = s2_wprod_r + W_ROUND;
  assign totx = (TOT_W'(s3_phx_r) << SPLIT) + TOT_W'(s3_plx_r) + G_ROUND;
  assign toty = (TOT_W'(s3_phy_r) << SPLIT) + TOT_W'(s3_ply_r) + G_ROUND;

  // Datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      // axis values and slopes
      s1_x_r    <= axis_eval(q_data.ax);
      s1_y_r    <= axis_eval(q_data.ay);
      s1_negx_r <= q_data.ax.neg;
      s1_negy_r <= q_data.ay.neg;
      s1_want_r <= q_data.want;
      s1_last_r <= q_data.last;

      // weight product and slope times other axis value
      s2_wprod_r <= WPROD_W'(s1_x_r.s) * WPROD_W'(s1_y_r.s);
      s2_ax_r    <= AX_W'(s1_x_r.d) * AX_W'(s1_y_r.s);
      s2_ay_r    <= AX_W'(s1_x_r.s) * AX_W'(s1_y_r.d);
      s2_negx_r  <= s1_negx_r;
      s2_negy_r  <= s1_negy_r;
      s2_want_r  <= s1_want_r;
      s2_last_r  <= s1_last_r;

      // weight rounding; cell-scale multiply split in two halves
      s3_weight_r <= wsum[WPROD_W-1:W_SHIFT];
      s3_phx_r    <= PHI_W'(s2_ax_r[AX_W-1:SPLIT]) * PHI_W'(twice_inv_x);
      s3_plx_r    <= PLO_W'(s2_ax_r[SPLIT-1:0]) * PLO_W'(twice_inv_x);
      s3_phy_r    <= PHI_W'(s2_ay_r[AX_W-1:SPLIT]) * PHI_W'(twice_inv_y);
      s3_ply_r    <= PLO_W'(s2_ay_r[SPLIT-1:0]) * PLO_W'(twice_inv_y);
      s3_negx_r   <= s2_negx_r;
      s3_negy_r   <= s2_negy_r;
      s3_want_r   <= s2_want_r;
      s3_last_r   <= s2_last_r;

      // gradient magnitude, rounded half up; zero when not requested
      s4_weight_r <= s3_weight_r;
      s4_magx_r   <= s3_want_r ? totx[G_SHIFT +: MAG_W] : '0;
      s4_magy_r   <= s3_want_r ? toty[G_SHIFT +: MAG_W] : '0;
      s4_negx_r   <= s3_negx_r;
      s4_negy_r   <= s3_negy_r;
      s4_last_r   <= s3_last_r;

      // sign; magnitude is below 2^31 so the signed range is never exceeded
      out_weight_r <= W_W'(s4_weight_r);
      out_gx_r     <= s4_negx_r ? -GRAD_W'(s4_magx_r) : GRAD_W'(s4_magx_r);
      out_gy_r     <= s4_negy_r ? -GRAD_W'(s4_magy_r) : GRAD_W'(s4_magy_r);
      out_last_r   <= s4_last_r;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.weight   = out_weight_r;
  assign out_ch.grad_x   = out_gx_r;
  assign out_ch.grad_y   = out_gy_r;
  assign out_ch.last_out = out_last_r;

endmodule
